FILE: design/ffrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffrc_pkg;

   // Image geometry limits.
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   // Field and counter widths.
   localparam int COORD_W = 6;
   localparam int DIM_W   = 7;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int CSR_IDX_W = 1;

   // Cell word layout: pixel bit over visited bit.
   localparam int CELL_W   = 2;
   localparam int CELL_PIX = 1;
   localparam int CELL_VIS = 0;

   // Stack word holds a coordinate pair {y, x}.
   localparam int STACK_W = 2 * COORD_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // Input beat kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Neighbor order: left, down, right, up.
   localparam logic [1:0] NB_LEFT  = 2'd0;
   localparam logic [1:0] NB_DOWN  = 2'd1;
   localparam logic [1:0] NB_RIGHT = 2'd2;
   localparam logic [1:0] NB_UP    = 2'd3;

   // Sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CLEAR    = 6'b000010,
      ST_NB_RD    = 6'b000100,
      ST_NB_CHK   = 6'b001000,
      ST_POP      = 6'b010000,
      ST_POP_WAIT = 6'b100000
   } state_type;

   // Saturate a size register to the range one through maxv.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] result;
      begin
         if (value == '0) begin
            result = DIM_W'(1);
         end else if (value > maxv) begin
            result = maxv;
         end else begin
            result = value;
         end
         return result;
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/ffrc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffrc_ram #(
   parameter int DATA_W = 1,
   parameter int ADDR_W = 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/flood_fill_region_count_top.sv
// Pixel loads: one beat per cycle while no query walks, no result.
// Query: the visited bits of the W*H cells are swept clear first, then the seed is checked,
// and each region pixel is popped, its stack entry read and its four neighbors read and
// checked in turn on the cell memory, before the result is registered.
// One query is in flight at a time; loads wait while a query walks.
// Reset is synchronous: control, sizes (64 by 64) and load position clear; pixels undefined.
`timescale 1ns / 1ps
`default_nettype none

module flood_fill_region_count_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_kind,
   input  wire logic                                 req_pixel_is_black,
   input  wire logic [ffrc_pkg::COORD_W-1:0]         req_seed_x,
   input  wire logic [ffrc_pkg::COORD_W-1:0]         req_seed_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [ffrc_pkg::CNT_W-1:0]           rsp_region_size,
   input  wire logic                                 csr_write_enable,
   input  wire logic [ffrc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ffrc_pkg::DIM_W-1:0]           csr_write_data
);

   localparam logic [ffrc_pkg::DIM_W-1:0] MaxW = ffrc_pkg::DIM_W'(ffrc_pkg::MAX_WIDTH);
   localparam logic [ffrc_pkg::DIM_W-1:0] MaxH = ffrc_pkg::DIM_W'(ffrc_pkg::MAX_HEIGHT);

   ffrc_pkg::state_type state_ff, state_in;

   logic [ffrc_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [ffrc_pkg::DIM_W-1:0]   height_ff, height_in;
   logic [ffrc_pkg::ADDR_W-1:0]  load_pos_ff, load_pos_in;
   logic [ffrc_pkg::CNT_W-1:0]   sp_ff, sp_in;
   logic [ffrc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ffrc_pkg::CNT_W-1:0]   clr_ff, clr_in;
   logic [1:0]                   nb_sel_ff, nb_sel_in;
   logic                         seed_phase_ff, seed_phase_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ffrc_pkg::CNT_W-1:0]   rsp_size_ff, rsp_size_in;
   logic [ffrc_pkg::COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [ffrc_pkg::COORD_W-1:0] cur_y_ff, cur_y_in;
   logic [ffrc_pkg::COORD_W-1:0] nb_x_ff, nb_x_in;
   logic [ffrc_pkg::COORD_W-1:0] nb_y_ff, nb_y_in;
   logic [ffrc_pkg::ADDR_W-1:0]  nb_addr_ff, nb_addr_in;

   logic [ffrc_pkg::DIM_W-1:0]   w_eff;
   logic [ffrc_pkg::DIM_W-1:0]   h_eff;
   logic [ffrc_pkg::PROD_W-1:0]  area_full;
   logic [ffrc_pkg::CNT_W-1:0]   total;
   logic [ffrc_pkg::ADDR_W-1:0]  load_next;

   logic [ffrc_pkg::DIM_W-1:0]   cx_ext;
   logic [ffrc_pkg::DIM_W-1:0]   cy_ext;
   logic [ffrc_pkg::DIM_W-1:0]   nx;
   logic [ffrc_pkg::DIM_W-1:0]   ny;
   logic                         nb_ok;
   logic [ffrc_pkg::PROD_W-1:0]  nb_addr_full;

   logic                         req_take;
   logic                         last_nb;

   logic                         cell_wr_en;
   logic [ffrc_pkg::ADDR_W-1:0]  cell_wr_addr;
   logic [ffrc_pkg::CELL_W-1:0]  cell_wr_data;
   logic                         cell_rd_en;
   logic [ffrc_pkg::ADDR_W-1:0]  cell_rd_addr;
   logic [ffrc_pkg::CELL_W-1:0]  cell_rd_data;

   logic                         stk_wr_en;
   logic [ffrc_pkg::ADDR_W-1:0]  stk_wr_addr;
   logic [ffrc_pkg::STACK_W-1:0] stk_wr_data;
   logic                         stk_rd_en;
   logic [ffrc_pkg::ADDR_W-1:0]  stk_rd_addr;
   logic [ffrc_pkg::STACK_W-1:0] stk_rd_data;

   // Effective image size and cell count.
   assign w_eff     = ffrc_pkg::clamp_dim(width_ff, MaxW);
   assign h_eff     = ffrc_pkg::clamp_dim(height_ff, MaxH);
   assign area_full = w_eff * h_eff;
   assign total     = area_full[ffrc_pkg::CNT_W-1:0];

   // Next raster position with wrap at the end of the image.
   always_comb begin
      if ({1'b0, load_pos_ff} + ffrc_pkg::CNT_W'(1) >= total) begin
         load_next = '0;
      end else begin
         load_next = load_pos_ff + ffrc_pkg::ADDR_W'(1);
      end
   end

   // Candidate cell: the seed itself, or one of the four neighbors.
   assign cx_ext = {1'b0, cur_x_ff};
   assign cy_ext = {1'b0, cur_y_ff};

   always_comb begin
      nx    = cx_ext;
      ny    = cy_ext;
      nb_ok = 1'b1;
      if (!seed_phase_ff) begin
         unique case (nb_sel_ff)
            ffrc_pkg::NB_LEFT: begin
               nx    = cx_ext - ffrc_pkg::DIM_W'(1);
               nb_ok = (cur_x_ff != '0);
            end
            ffrc_pkg::NB_DOWN: begin
               ny = cy_ext + ffrc_pkg::DIM_W'(1);
            end
            ffrc_pkg::NB_RIGHT: begin
               nx = cx_ext + ffrc_pkg::DIM_W'(1);
            end
            ffrc_pkg::NB_UP: begin
               ny    = cy_ext - ffrc_pkg::DIM_W'(1);
               nb_ok = (cur_y_ff != '0);
            end
            default: begin
               nb_ok = 1'b0;
            end
         endcase
      end
      nb_ok = nb_ok && (nx < w_eff) && (ny < h_eff);
   end

   assign nb_addr_full = ny * w_eff + ffrc_pkg::PROD_W'(nx);

   assign req_stall = (state_ff != ffrc_pkg::ST_IDLE) ||
                      (rsp_valid_ff && (req_kind == ffrc_pkg::KIND_QUERY));
   assign req_take  = req_valid && !req_stall;
   assign last_nb   = seed_phase_ff || (nb_sel_ff == ffrc_pkg::NB_UP);

   // Sequencer and memory port control.
   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      load_pos_in   = load_pos_ff;
      sp_in         = sp_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      nb_sel_in     = nb_sel_ff;
      seed_phase_in = seed_phase_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_size_in   = rsp_size_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      nb_x_in       = nb_x_ff;
      nb_y_in       = nb_y_ff;
      nb_addr_in    = nb_addr_ff;

      cell_wr_en    = 1'b0;
      cell_wr_addr  = load_pos_ff;
      cell_wr_data  = {req_pixel_is_black, 1'b0};
      cell_rd_en    = 1'b0;
      cell_rd_addr  = nb_addr_full[ffrc_pkg::ADDR_W-1:0];
      stk_wr_en     = 1'b0;
      stk_wr_addr   = sp_ff[ffrc_pkg::ADDR_W-1:0];
      stk_wr_data   = {nb_y_ff, nb_x_ff};
      stk_rd_en     = 1'b0;
      stk_rd_addr   = sp_ff[ffrc_pkg::ADDR_W-1:0];

      unique case (state_ff)
         ffrc_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_kind == ffrc_pkg::KIND_LOAD) begin
                  cell_wr_en  = 1'b1;
                  load_pos_in = load_next;
               end else begin
                  cur_x_in      = req_seed_x;
                  cur_y_in      = req_seed_y;
                  seed_phase_in = 1'b1;
                  sp_in         = '0;
                  count_in      = '0;
                  clr_in        = '0;
                  state_in      = ffrc_pkg::ST_CLEAR;
               end
            end
         end

         // Read a cell, write the previous one back with its visited bit low.
         ffrc_pkg::ST_CLEAR: begin
            cell_rd_en   = (clr_ff < total);
            cell_rd_addr = clr_ff[ffrc_pkg::ADDR_W-1:0];
            cell_wr_en   = (clr_ff != '0);
            cell_wr_addr = clr_ff[ffrc_pkg::ADDR_W-1:0] - ffrc_pkg::ADDR_W'(1);
            cell_wr_data = {cell_rd_data[ffrc_pkg::CELL_PIX], 1'b0};
            if (clr_ff == total) begin
               state_in = ffrc_pkg::ST_NB_RD;
            end else begin
               clr_in = clr_ff + ffrc_pkg::CNT_W'(1);
            end
         end

         ffrc_pkg::ST_NB_RD: begin
            if (nb_ok) begin
               cell_rd_en = 1'b1;
               nb_addr_in = nb_addr_full[ffrc_pkg::ADDR_W-1:0];
               nb_x_in    = nx[ffrc_pkg::COORD_W-1:0];
               nb_y_in    = ny[ffrc_pkg::COORD_W-1:0];
               state_in   = ffrc_pkg::ST_NB_CHK;
            end else if (last_nb) begin
               seed_phase_in = 1'b0;
               state_in      = ffrc_pkg::ST_POP;
            end else begin
               nb_sel_in = nb_sel_ff + 2'd1;
            end
         end

         // Mark and push an unvisited black cell.
         ffrc_pkg::ST_NB_CHK: begin
            if (cell_rd_data[ffrc_pkg::CELL_PIX] && !cell_rd_data[ffrc_pkg::CELL_VIS]) begin
               cell_wr_en   = 1'b1;
               cell_wr_addr = nb_addr_ff;
               cell_wr_data = {1'b1, 1'b1};
               stk_wr_en    = 1'b1;
               sp_in        = sp_ff + ffrc_pkg::CNT_W'(1);
            end
            if (last_nb) begin
               seed_phase_in = 1'b0;
               state_in      = ffrc_pkg::ST_POP;
            end else begin
               nb_sel_in = nb_sel_ff + 2'd1;
               state_in  = ffrc_pkg::ST_NB_RD;
            end
         end

         // Read the top entry of the stack, or return the count once the stack is empty.
         ffrc_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = count_ff;
               state_in     = ffrc_pkg::ST_IDLE;
            end else begin
               sp_in       = sp_ff - ffrc_pkg::CNT_W'(1);
               stk_rd_en   = 1'b1;
               stk_rd_addr = sp_ff[ffrc_pkg::ADDR_W-1:0] - ffrc_pkg::ADDR_W'(1);
               count_in    = count_ff + ffrc_pkg::CNT_W'(1);
               state_in    = ffrc_pkg::ST_POP_WAIT;
            end
         end

         ffrc_pkg::ST_POP_WAIT: begin
            cur_x_in  = stk_rd_data[ffrc_pkg::COORD_W-1:0];
            cur_y_in  = stk_rd_data[ffrc_pkg::STACK_W-1:ffrc_pkg::COORD_W];
            nb_sel_in = ffrc_pkg::NB_LEFT;
            state_in  = ffrc_pkg::ST_NB_RD;
         end

         default: begin
            state_in = ffrc_pkg::ST_IDLE;
         end
      endcase

      // Register writes; any write restarts the raster position.
      if (csr_write_enable) begin
         unique case (csr_index)
            ffrc_pkg::REG_IMAGE_WIDTH:  width_in  = csr_write_data;
            ffrc_pkg::REG_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
         load_pos_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffrc_pkg::ST_IDLE;
         width_ff      <= MaxW;
         height_ff     <= MaxH;
         load_pos_ff   <= '0;
         sp_ff         <= '0;
         count_ff      <= '0;
         clr_ff        <= '0;
         nb_sel_ff     <= ffrc_pkg::NB_LEFT;
         seed_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         load_pos_ff   <= load_pos_in;
         sp_ff         <= sp_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         nb_sel_ff     <= nb_sel_in;
         seed_phase_ff <= seed_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_size_ff <= rsp_size_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      nb_x_ff     <= nb_x_in;
      nb_y_ff     <= nb_y_in;
      nb_addr_ff  <= nb_addr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_region_size = rsp_size_ff;

   // Pixel and visited bits, one word per cell.
   ffrc_ram #(
      .DATA_W(ffrc_pkg::CELL_W),
      .ADDR_W(ffrc_pkg::ADDR_W)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (cell_wr_en),
      .wr_addr(cell_wr_addr),
      .wr_data(cell_wr_data),
      .rd_en  (cell_rd_en),
      .rd_addr(cell_rd_addr),
      .rd_data(cell_rd_data)
   );

   // Pending cell coordinates.
   ffrc_ram #(
      .DATA_W(ffrc_pkg::STACK_W),
      .ADDR_W(ffrc_pkg::ADDR_W)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (stk_wr_en),
      .wr_addr(stk_wr_addr),
      .wr_data(stk_wr_data),
      .rd_en  (stk_rd_en),
      .rd_addr(stk_rd_addr),
      .rd_data(stk_rd_data)
   );

endmodule

`default_nettype wire

FILE: design/ffrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ffrc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           req_kind,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [ffrc_pkg::CNT_W-1:0]     rsp_region_size
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_region_size))
      else $error("stalled result beat changed");

   // No result right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A region never exceeds the cell count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_region_size <= ffrc_pkg::CNT_W'(ffrc_pkg::DEPTH))
      else $error("region size beyond image area");

   // An accepted query occupies the block on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == ffrc_pkg::KIND_QUERY) |=> req_stall)
      else $error("input taken while a query walks");

   // A pixel load never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && (req_kind == ffrc_pkg::KIND_LOAD)
      |=> !rsp_valid)
      else $error("result appeared after a load");

endmodule

bind flood_fill_region_count_top ffrc_checker u_ffrc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_region_size(rsp_region_size)
);

`default_nettype wire

FILE: sim/flood_fill_region_count_top_tb.sv
`timescale 1ns / 1ps

module flood_fill_region_count_top_tb;

   localparam int CLOCK_PERIOD  = 20;
   localparam int QUIET_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_BEATS  = 620;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_kind;
   logic                           req_pixel_is_black;
   logic [ffrc_pkg::COORD_W-1:0]   req_seed_x;
   logic [ffrc_pkg::COORD_W-1:0]   req_seed_y;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [ffrc_pkg::CNT_W-1:0]     rsp_region_size;
   logic                           csr_write_enable;
   logic [ffrc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ffrc_pkg::DIM_W-1:0]     csr_write_data;

   // Shadow copy of the image, the size registers and the load pointer.
   bit                         pixel_mirror [ffrc_pkg::DEPTH];
   bit                         walk_seen [ffrc_pkg::DEPTH];
   int                         walk_stack [ffrc_pkg::DEPTH];
   int                         walk_depth;
   logic [ffrc_pkg::DIM_W-1:0] width_reg;
   logic [ffrc_pkg::DIM_W-1:0] height_reg;
   int                         load_addr;

   // Region sizes still owed by the block, oldest first.
   logic [ffrc_pkg::CNT_W-1:0] expected_sizes [$];

   int gap_max;
   int error_count;
   int load_count;
   int query_count;
   int checked_count;
   int frame_count;
   int largest_region;

   flood_fill_region_count_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_pixel_is_black (req_pixel_is_black),
      .req_seed_x         (req_seed_x),
      .req_seed_y         (req_seed_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_region_size    (rsp_region_size),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // A size register of zero acts as one; anything above the limit acts as the limit.
   function automatic int eff_size(input logic [ffrc_pkg::DIM_W-1:0] value, input int limit);
      if (value == '0) return 1;
      if (value > limit) return limit;
      return int'(value);
   endfunction

   // Push a neighbor when it lies in the image, is black and was not seen yet.
   function automatic void mark_and_push(input int x, input int y, input int w, input int h);
      int a;
      if (x < 0 || y < 0 || x >= w || y >= h) return;
      a = y * w + x;
      if (walk_seen[a] || !pixel_mirror[a]) return;
      walk_seen[a] = 1'b1;
      walk_stack[walk_depth] = a;
      walk_depth++;
   endfunction

   // Size of the 4-connected black region that holds the seed.
   function automatic logic [ffrc_pkg::CNT_W-1:0] count_region(
         input logic [ffrc_pkg::COORD_W-1:0] sx,
         input logic [ffrc_pkg::COORD_W-1:0] sy);
      int w;
      int h;
      int a;
      int x;
      int y;
      int n;
      w = eff_size(width_reg, ffrc_pkg::MAX_WIDTH);
      h = eff_size(height_reg, ffrc_pkg::MAX_HEIGHT);
      n = 0;
      walk_depth = 0;
      foreach (walk_seen[i]) walk_seen[i] = 1'b0;
      mark_and_push(int'(sx), int'(sy), w, h);
      while (walk_depth > 0) begin
         walk_depth--;
         a = walk_stack[walk_depth];
         x = a % w;
         y = a / w;
         n++;
         mark_and_push(x - 1, y, w, h);
         mark_and_push(x, y + 1, w, h);
         mark_and_push(x + 1, y, w, h);
         mark_and_push(x, y - 1, w, h);
      end
      return ffrc_pkg::CNT_W'(n);
   endfunction

   task automatic report_mismatch(input string what, input logic [ffrc_pkg::CNT_W-1:0] want,
                                  input logic [ffrc_pkg::CNT_W-1:0] got);
      error_count++;
      $display("MISMATCH at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Offer one beat after a random gap and update the shadow state once it is taken.
   task automatic send_beat(input logic kind, input logic black,
                            input logic [ffrc_pkg::COORD_W-1:0] sx,
                            input logic [ffrc_pkg::COORD_W-1:0] sy);
      int gap;
      int total;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_pixel_is_black <= black;
      req_seed_x         <= sx;
      req_seed_y         <= sy;
      do @(negedge clock); while (req_stall !== 1'b0);
      if (kind == ffrc_pkg::KIND_QUERY) begin
         expected_sizes.push_back(count_region(sx, sy));
         query_count++;
      end else begin
         total = eff_size(width_reg, ffrc_pkg::MAX_WIDTH) *
                 eff_size(height_reg, ffrc_pkg::MAX_HEIGHT);
         if (load_addr >= total) load_addr = 0;
         pixel_mirror[load_addr] = black;
         load_addr++;
         if (load_addr >= total) load_addr = 0;
         load_count++;
      end
      @(posedge clock);
   endtask

   task automatic load_pixel(input logic black);
      send_beat(ffrc_pkg::KIND_LOAD, black, ffrc_pkg::COORD_W'($urandom_range(63, 0)),
                ffrc_pkg::COORD_W'($urandom_range(63, 0)));
   endtask

   task automatic ask_region(input logic [ffrc_pkg::COORD_W-1:0] sx,
                             input logic [ffrc_pkg::COORD_W-1:0] sy);
      send_beat(ffrc_pkg::KIND_QUERY, 1'($urandom_range(1, 0)), sx, sy);
   endtask

   // Fill the whole configured image; pct is the chance of a black pixel.
   task automatic load_frame(input int pct);
      int total;
      total = eff_size(width_reg, ffrc_pkg::MAX_WIDTH) *
              eff_size(height_reg, ffrc_pkg::MAX_HEIGHT);
      repeat (total) load_pixel($urandom_range(99, 0) < pct);
   endtask

   // Load n pixels from a bit pattern, lowest bit first.
   task automatic load_bits(input logic [63:0] bits, input int n);
      for (int i = 0; i < n; i++) load_pixel(bits[i]);
   endtask

   // Register writes wait until the block has returned every owed result.
   task automatic write_size_reg(input logic [ffrc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ffrc_pkg::DIM_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_sizes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == ffrc_pkg::REG_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      load_addr = 0;
   endtask

   task automatic set_image_size(input logic [ffrc_pkg::DIM_W-1:0] w,
                                 input logic [ffrc_pkg::DIM_W-1:0] h);
      if ($urandom_range(1, 0) == 1) begin
         write_size_reg(ffrc_pkg::REG_IMAGE_WIDTH, w);
         write_size_reg(ffrc_pkg::REG_IMAGE_HEIGHT, h);
      end else begin
         write_size_reg(ffrc_pkg::REG_IMAGE_HEIGHT, h);
         write_size_reg(ffrc_pkg::REG_IMAGE_WIDTH, w);
      end
   endtask

   // Reset sizes: the top two rows of the 64 by 64 image, streamed back to back.
   task automatic test_full_frame();
      gap_max = 0;
      load_bits(~(64'd1 << 40), ffrc_pkg::MAX_WIDTH);
      load_bits(64'd0, ffrc_pkg::MAX_WIDTH);
      gap_max = 5;
      // Seeds stay in the loaded rows; the white second row bounds every walk.
      ask_region(6'd0, 6'd0);
      ask_region(6'd63, 6'd0);
      ask_region(6'd40, 6'd0);
      ask_region(6'd17, 6'd1);
   endtask

   // Zero sizes act as a single pixel; seeds past the edge give nothing.
   task automatic test_tiny_sizes();
      set_image_size(7'd0, 7'd0);
      ask_region(6'd1, 6'd0);
      ask_region(6'd0, 6'd63);
      load_pixel(1'b1);
      ask_region(6'd0, 6'd0);
      load_pixel(1'b0);
      ask_region(6'd0, 6'd0);
   endtask

   // An oversized width saturates to a single full row; then a full column; then both saturate.
   task automatic test_row_and_column();
      set_image_size(7'd127, 7'd1);
      load_bits(~(64'd1 << 31), ffrc_pkg::MAX_WIDTH);
      ask_region(6'd0, 6'd0);
      ask_region(6'd63, 6'd0);
      ask_region(6'd31, 6'd0);
      ask_region(6'd40, 6'd1);
      set_image_size(7'd1, 7'd64);
      load_bits({64{1'b1}}, ffrc_pkg::MAX_HEIGHT);
      ask_region(6'd0, 6'd63);
      ask_region(6'd1, 6'd0);
      set_image_size(7'd65, 7'd127);
      ask_region(6'd20, 6'd0);
   endtask

   // Loads wrap after a full frame, and any register write rewinds them.
   task automatic test_load_position();
      set_image_size(7'd3, 7'd3);
      load_bits(64'b010_111_010, 9);
      ask_region(6'd1, 6'd1);
      load_bits(64'b1111, 4);
      ask_region(6'd0, 6'd0);
      write_size_reg(ffrc_pkg::REG_IMAGE_WIDTH, 7'd3);
      load_bits(64'b00, 2);
      ask_region(6'd2, 6'd0);
   endtask

   // Diagonal neighbors do not connect.
   task automatic test_checkerboard();
      set_image_size(7'd4, 7'd4);
      for (int a = 0; a < 16; a++) load_pixel(((a % 4) + (a / 4)) % 2 == 0);
      ask_region(6'd0, 6'd0);
      ask_region(6'd1, 6'd0);
      ask_region(6'd3, 6'd3);
   endtask

   // Random frames: mostly small sizes, a full load, then loads and queries mixed.
   task automatic test_random_frames();
      int start;
      int pct;
      int ew;
      int eh;
      int pick;
      int sx;
      int sy;
      logic [ffrc_pkg::DIM_W-1:0] w;
      logic [ffrc_pkg::DIM_W-1:0] h;
      start = load_count + query_count;
      while (load_count + query_count - start < RANDOM_BEATS) begin
         gap_max = ($urandom_range(3, 0) == 0) ? 0 : 5;
         case ($urandom_range(19, 0))
            0: begin
               w = ffrc_pkg::DIM_W'($urandom_range(127, 64));
               h = ffrc_pkg::DIM_W'($urandom_range(4, 1));
            end
            1: begin
               w = ffrc_pkg::DIM_W'($urandom_range(3, 1));
               h = ffrc_pkg::DIM_W'($urandom_range(127, 64));
            end
            2: begin
               w = ffrc_pkg::DIM_W'($urandom_range(1, 0));
               h = ffrc_pkg::DIM_W'($urandom_range(12, 0));
            end
            default: begin
               w = ffrc_pkg::DIM_W'($urandom_range(10, 1));
               h = ffrc_pkg::DIM_W'($urandom_range(10, 1));
            end
         endcase
         set_image_size(w, h);
         ew = eff_size(width_reg, ffrc_pkg::MAX_WIDTH);
         eh = eff_size(height_reg, ffrc_pkg::MAX_HEIGHT);
         pct = $urandom_range(95, 30);
         load_frame(pct);
         repeat ($urandom_range(14, 3)) begin
            if ($urandom_range(99, 0) < 35) begin
               pick = $urandom_range(99, 0);
               if (pick < 85) begin
                  // Prefer a black seed so the walk has something to cover.
                  sx = $urandom_range(ew - 1, 0);
                  sy = $urandom_range(eh - 1, 0);
                  for (int t = 0; t < 8 && pick < 60 && !pixel_mirror[sy * ew + sx]; t++) begin
                     sx = $urandom_range(ew - 1, 0);
                     sy = $urandom_range(eh - 1, 0);
                  end
               end else begin
                  sx = $urandom_range(63, 0);
                  sy = $urandom_range(63, 0);
               end
               ask_region(ffrc_pkg::COORD_W'(sx), ffrc_pkg::COORD_W'(sy));
            end else begin
               load_pixel($urandom_range(99, 0) < pct);
            end
         end
         frame_count++;
      end
   endtask

   // Result side: stall each beat for a random hold, possibly none, then check it.
   initial begin : result_checker
      logic [ffrc_pkg::CNT_W-1:0] want;
      int hold;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = $urandom_range(gap_max, 0);
         rsp_stall <= (hold > 0);
         do @(negedge clock); while (rsp_valid !== 1'b1);
         if (hold > 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
         if (expected_sizes.size() == 0) begin
            report_mismatch("region_size beat with no query pending", '0, rsp_region_size);
         end else begin
            want = expected_sizes.pop_front();
            if (rsp_region_size !== want) report_mismatch("region_size", want, rsp_region_size);
            checked_count++;
            if (int'(want) > largest_region) largest_region = int'(want);
         end
         @(posedge clock);
      end
   end

   // Give up when no beat moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_kind           <= ffrc_pkg::KIND_LOAD;
      req_pixel_is_black <= 1'b0;
      req_seed_x         <= '0;
      req_seed_y         <= '0;
      rsp_stall          <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_index          <= ffrc_pkg::REG_IMAGE_WIDTH;
      csr_write_data     <= '0;
      width_reg      = ffrc_pkg::DIM_W'(ffrc_pkg::MAX_WIDTH);
      height_reg     = ffrc_pkg::DIM_W'(ffrc_pkg::MAX_HEIGHT);
      load_addr      = 0;
      gap_max        = 5;
      error_count    = 0;
      load_count     = 0;
      query_count    = 0;
      checked_count  = 0;
      frame_count    = 0;
      largest_region = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_frame();
      test_tiny_sizes();
      test_row_and_column();
      test_load_position();
      test_checkerboard();
      test_random_frames();

      // Drain every owed result, then watch for strays.
      req_valid <= 1'b0;
      while (expected_sizes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixel loads and %0d region queries (%0d random frames).",
               load_count, query_count, frame_count);
      $display("Checked %0d region sizes, largest %0d; %0d mismatches.",
               checked_count, largest_region, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
